@@ hdl/svic_pkg.sv @@
// Shared types, constants and a helper function of the sprite VM instruction core.
`timescale 1ns / 1ps

package svic_pkg;

    localparam int C_MEM_BYTES   = 4096;
    localparam int C_ADDR_W      = 12;
    localparam int C_STACK_DEPTH = 16;
    localparam int C_SCREEN_W    = 64;
    localparam int C_SCREEN_H    = 32;
    localparam logic [11:0] C_START_RESET = 12'h200;

    // Item kinds.
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_EXEC = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVER  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_UNSUP = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_START = 2'd0;
    localparam logic [1:0] CFG_SHIFT = 2'd1;
    localparam logic [1:0] CFG_JUMP  = 2'd2;

    // Instruction words and sub-codes.
    localparam logic [15:0] INS_CLS  = 16'h00E0;
    localparam logic [15:0] INS_RET  = 16'h00EE;
    localparam logic [7:0]  NN_SKP   = 8'h9E;
    localparam logic [7:0]  NN_SKNP  = 8'hA1;
    localparam logic [7:0]  NN_GETDT = 8'h07;
    localparam logic [7:0]  NN_SETDT = 8'h15;
    localparam logic [7:0]  NN_SETST = 8'h18;
    localparam logic [7:0]  NN_ADDI  = 8'h1E;
    localparam logic [7:0]  NN_WAIT  = 8'h0A;
    localparam logic [7:0]  NN_FONT  = 8'h29;
    localparam logic [7:0]  NN_BCD   = 8'h33;
    localparam logic [7:0]  NN_STORE = 8'h55;
    localparam logic [7:0]  NN_LOAD  = 8'h65;
    localparam logic [11:0] C_ADDR_MAX = 12'hFFF;

    typedef enum logic [3:0] {
        ALU_MOV,
        ALU_OR,
        ALU_AND,
        ALU_XOR,
        ALU_ADD,
        ALU_SUB,
        ALU_SUBN,
        ALU_SHR,
        ALU_SHL
    } t_alu_fn;

    typedef struct packed {
        t_alu_fn    fn;
        logic [7:0] a;
        logic [7:0] b;
    } t_alu_req;

    typedef struct packed {
        logic [7:0] res;
        logic       flag;
    } t_alu_rsp;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] load_address;
        logic [7:0]  load_data;
        logic [15:0] key_bitmap;
        logic [7:0]  random_byte;
        logic [4:0]  row_select;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] pc_now;
        logic [63:0] row_bits;
        logic [7:0]  sound_level;
    } t_out;

    // Decimal digit of a byte: 0 hundreds, 1 tens, otherwise units.
    function automatic logic [7:0] bcd_digit(input logic [7:0] v, input logic [1:0] sel);
        logic [1:0] h;
        logic [6:0] r;
        logic [3:0] t;
        logic [3:0] u;
        if (v >= 8'd200) begin
            h = 2'd2;
            r = 7'(v - 8'd200);
        end else if (v >= 8'd100) begin
            h = 2'd1;
            r = 7'(v - 8'd100);
        end else begin
            h = 2'd0;
            r = v[6:0];
        end
        t = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= 7'(10 * k)) begin
                t = 4'(k);
            end
        end
        u = 4'(r - 7'({t, 3'b000}) - 7'({t, 1'b0}));
        case (sel)
            2'd0:    bcd_digit = {6'd0, h};
            2'd1:    bcd_digit = {4'd0, t};
            default: bcd_digit = {4'd0, u};
        endcase
    endfunction

endpackage

@@ hdl/svic_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module svic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/svic_alu.sv @@
// Shared 8-bit arithmetic, logic and shift unit with flag output.
`timescale 1ns / 1ps

module svic_alu
    import svic_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [8:0] w_sum;

    assign w_sum = {1'b0, i_req.a} + {1'b0, i_req.b};

    always_comb begin
        o_rsp.res  = i_req.b;
        o_rsp.flag = 1'b0;
        case (i_req.fn)
            ALU_MOV: begin
                o_rsp.res = i_req.b;
            end
            ALU_OR: begin
                o_rsp.res = i_req.a | i_req.b;
            end
            ALU_AND: begin
                o_rsp.res = i_req.a & i_req.b;
            end
            ALU_XOR: begin
                o_rsp.res = i_req.a ^ i_req.b;
            end
            ALU_ADD: begin
                o_rsp.res  = w_sum[7:0];
                o_rsp.flag = w_sum[8];
            end
            ALU_SUB: begin
                o_rsp.res  = i_req.a - i_req.b;
                o_rsp.flag = (i_req.a > i_req.b);
            end
            ALU_SUBN: begin
                o_rsp.res  = i_req.b - i_req.a;
                o_rsp.flag = (i_req.b > i_req.a);
            end
            ALU_SHR: begin
                o_rsp.res  = {1'b0, i_req.a[7:1]};
                o_rsp.flag = i_req.a[0];
            end
            ALU_SHL: begin
                o_rsp.res  = {i_req.a[6:0], 1'b0};
                o_rsp.flag = i_req.a[7];
            end
            default: begin
                o_rsp.res  = i_req.b;
                o_rsp.flag = 1'b0;
            end
        endcase
    end

endmodule

@@ hdl/sprite_vm_instruction_core.sv @@
// Top level of the sprite VM instruction core: sequencer, register file, stack and display.
// Load, read and other non-execute items go straight to completion; an instruction is fetched, its operands
// read and executed, then a sprite draw, register load, store or BCD steps once per row or byte.
// One item is in flight at a time; the memory port and the one shared ALU set the pace.
// After reset a clearing pass zeroes all 4096 bytes of main memory before any item is taken.
// Synchronous active-low reset clears registers, display, stack level and output valid.
`timescale 1ns / 1ps

module sprite_vm_instruction_core
    import svic_pkg::*;
#(
    parameter int STACK_DEPTH = C_STACK_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    localparam int SP_W = $clog2(STACK_DEPTH + 1);
    localparam int SI_W = $clog2(STACK_DEPTH);

    typedef enum logic [13:0] {
        S_CLR  = 14'b00000000000001,
        S_IDLE = 14'b00000000000010,
        S_F0   = 14'b00000000000100,
        S_F1   = 14'b00000000001000,
        S_RDX  = 14'b00000000010000,
        S_RDY  = 14'b00000000100000,
        S_EXEC = 14'b00000001000000,
        S_DRA  = 14'b00000010000000,
        S_DRB  = 14'b00000100000000,
        S_STO  = 14'b00001000000000,
        S_LDA  = 14'b00010000000000,
        S_LDB  = 14'b00100000000000,
        S_BCD  = 14'b01000000000000,
        S_DONE = 14'b10000000000000
    } t_state;

    t_state       r_state;
    logic [11:0]  r_clr;
    logic [11:0]  r_pc;
    logic [15:0]  r_i;
    logic [7:0]   r_dt;
    logic [7:0]   r_st;
    logic [SP_W-1:0] r_sp;
    logic [7:0]   r_regs [16];
    logic [11:0]  r_stack [STACK_DEPTH];
    logic [63:0]  r_frame [C_SCREEN_H];
    logic [15:0]  r_ins;
    logic [7:0]   r_vx;
    logic [7:0]   r_vy;
    logic [15:0]  r_keys;
    logic [7:0]   r_rnd;
    logic [3:0]   r_cnt;
    logic [1:0]   r_status;
    logic [63:0]  r_row;
    logic         r_shift_vy;
    logic         r_jump_vx;
    logic         r_out_valid;
    t_out         r_out;

    logic         w_in_acc;
    logic [3:0]   w_opc;
    logic [3:0]   w_x;
    logic [3:0]   w_y;
    logic [3:0]   w_n;
    logic [7:0]   w_nn;
    logic [11:0]  w_nnn;
    logic [3:0]   w_reg_ra;
    logic [7:0]   w_reg_rd;
    logic [11:0]  w_ix_addr;
    logic [11:0]  w_raddr;
    logic         w_we;
    logic [11:0]  w_waddr;
    logic [7:0]   w_wdata;
    logic [7:0]   w_rdata;
    t_alu_req     w_alu_req;
    t_alu_rsp     w_alu_rsp;
    logic         w_key;
    logic [7:0]   w_shift_src;
    logic [11:0]  w_next;
    logic [1:0]   w_stat;
    logic [SP_W-1:0] w_sp_dec;
    logic [15:0]  w_i_sum;
    logic [4:0]   w_draw_row;
    logic [4:0]   w_frow;
    logic [63:0]  w_frame_rd;
    logic [127:0] w_wide;
    logic [63:0]  w_mask;

    assign w_in_acc    = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_opc = r_ins[15:12];
    assign w_x   = r_ins[11:8];
    assign w_y   = r_ins[7:4];
    assign w_n   = r_ins[3:0];
    assign w_nn  = r_ins[7:0];
    assign w_nnn = r_ins[11:0];

    // One read port on the register file, shared by the sequencer steps.
    always_comb begin
        case (r_state)
            S_RDX:   w_reg_ra = w_x;
            S_RDY:   w_reg_ra = (w_opc == 4'hB && !r_jump_vx) ? 4'd0 : w_y;
            default: w_reg_ra = r_cnt;
        endcase
    end
    assign w_reg_rd = r_regs[w_reg_ra];

    assign w_ix_addr = r_i[11:0] + {8'd0, r_cnt};

    always_comb begin
        case (r_state)
            S_F0:    w_raddr = r_pc;
            S_F1:    w_raddr = r_pc + 12'd1;
            S_DRA:   w_raddr = w_ix_addr;
            S_LDA:   w_raddr = w_ix_addr;
            default: w_raddr = r_pc;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_ix_addr;
        w_wdata = w_reg_rd;
        case (r_state)
            S_CLR: begin
                w_we    = 1'b1;
                w_waddr = r_clr;
                w_wdata = 8'd0;
            end
            S_IDLE: begin
                w_we    = w_in_acc && (i_in.op == OP_LOAD);
                w_waddr = i_in.load_address;
                w_wdata = i_in.load_data;
            end
            S_STO: begin
                w_we = 1'b1;
            end
            S_BCD: begin
                w_we    = 1'b1;
                w_wdata = bcd_digit(r_vx, r_cnt[1:0]);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    svic_ram #(
        .WIDTH (8),
        .DEPTH (C_MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_shift_src = r_shift_vy ? r_vy : r_vx;

    always_comb begin
        w_alu_req.fn = ALU_MOV;
        w_alu_req.a  = r_vx;
        w_alu_req.b  = w_nn;
        case (w_opc)
            4'h3, 4'h4: begin
                w_alu_req.fn = ALU_SUB;
            end
            4'h5, 4'h9: begin
                w_alu_req.fn = ALU_SUB;
                w_alu_req.b  = r_vy;
            end
            4'h7: begin
                w_alu_req.fn = ALU_ADD;
            end
            4'hC: begin
                w_alu_req.fn = ALU_AND;
                w_alu_req.a  = r_rnd;
            end
            4'h8: begin
                w_alu_req.b = r_vy;
                case (w_n)
                    4'h1:    w_alu_req.fn = ALU_OR;
                    4'h2:    w_alu_req.fn = ALU_AND;
                    4'h3:    w_alu_req.fn = ALU_XOR;
                    4'h4:    w_alu_req.fn = ALU_ADD;
                    4'h5:    w_alu_req.fn = ALU_SUB;
                    4'h7:    w_alu_req.fn = ALU_SUBN;
                    4'h6: begin
                        w_alu_req.fn = ALU_SHR;
                        w_alu_req.a  = w_shift_src;
                    end
                    4'hE: begin
                        w_alu_req.fn = ALU_SHL;
                        w_alu_req.a  = w_shift_src;
                    end
                    default: w_alu_req.fn = ALU_MOV;
                endcase
            end
            default: begin
                w_alu_req.fn = ALU_MOV;
            end
        endcase
    end

    svic_alu u_alu (
        .i_req (w_alu_req),
        .o_rsp (w_alu_rsp)
    );

    assign w_key    = r_keys[r_vx[3:0]];
    assign w_sp_dec = r_sp - 1'b1;
    assign w_i_sum  = r_i + {8'd0, r_vx};

    // Next program counter and status of the instruction held in r_ins.
    always_comb begin
        w_next = r_pc + 12'd2;
        w_stat = ST_OK;
        case (w_opc)
            4'h0: begin
                if (r_ins == INS_RET) begin
                    if (r_sp == '0) begin
                        w_stat = ST_UNDER;
                        w_next = r_pc;
                    end else begin
                        w_next = r_stack[w_sp_dec[SI_W-1:0]];
                    end
                end
            end
            4'h1: w_next = w_nnn;
            4'h2: begin
                if (r_sp >= SP_W'(STACK_DEPTH)) begin
                    w_stat = ST_OVER;
                    w_next = r_pc;
                end else begin
                    w_next = w_nnn;
                end
            end
            4'h3: if (w_alu_rsp.res == 8'd0) w_next = r_pc + 12'd4;
            4'h4: if (w_alu_rsp.res != 8'd0) w_next = r_pc + 12'd4;
            4'h5: if (w_alu_rsp.res == 8'd0) w_next = r_pc + 12'd4;
            4'h9: if (w_alu_rsp.res != 8'd0) w_next = r_pc + 12'd4;
            4'hB: w_next = w_nnn + {4'd0, (r_jump_vx ? r_vx : r_vy)};
            4'hE: begin
                if (w_nn == NN_SKP && w_key) begin
                    w_next = r_pc + 12'd4;
                end else if (w_nn == NN_SKNP && !w_key) begin
                    w_next = r_pc + 12'd4;
                end
            end
            4'hF: begin
                case (w_nn)
                    NN_WAIT: if (!w_key) w_next = r_pc;
                    NN_GETDT, NN_SETDT, NN_SETST, NN_ADDI, NN_FONT, NN_BCD,
                    NN_STORE, NN_LOAD: w_stat = ST_OK;
                    default: begin
                        w_stat = ST_UNSUP;
                        w_next = r_pc;
                    end
                endcase
            end
            default: w_stat = ST_OK;
        endcase
    end

    // Sprite row placed at its column, wrapping at the right edge.
    assign w_draw_row = 5'(r_vy[4:0] + 5'(r_cnt));
    assign w_frow     = (r_state == S_DRB) ? w_draw_row : i_in.row_select;
    assign w_frame_rd = r_frame[w_frow];
    assign w_wide     = {w_rdata, 56'd0, w_rdata, 56'd0};
    assign w_mask     = 64'(w_wide >> r_vx[5:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_pc        <= C_START_RESET;
            r_i         <= '0;
            r_dt        <= '0;
            r_st        <= '0;
            r_sp        <= '0;
            r_cnt       <= '0;
            r_status    <= ST_OK;
            r_shift_vy  <= 1'b0;
            r_jump_vx   <= 1'b1;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                r_regs[k] <= '0;
            end
            for (int k = 0; k < C_SCREEN_H; k++) begin
                r_frame[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_SHIFT: r_shift_vy <= i_cfg_data[0];
                    CFG_JUMP:  r_jump_vx  <= i_cfg_data[0];
                    default:   r_shift_vy <= r_shift_vy;
                endcase
            end
            if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 12'd1;
                    if (r_clr == C_ADDR_MAX) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_status <= ST_OK;
                        r_keys   <= i_in.key_bitmap;
                        r_rnd    <= i_in.random_byte;
                        r_row    <= (i_in.op == OP_READ) ? w_frame_rd : 64'd0;
                        r_state  <= (i_in.op == OP_EXEC) ? S_F0 : S_DONE;
                    end
                end
                S_F0: begin
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_ins[15:8] <= w_rdata;
                    r_state     <= S_RDX;
                end
                S_RDX: begin
                    r_ins[7:0] <= w_rdata;
                    r_vx       <= w_reg_rd;
                    r_state    <= S_RDY;
                end
                S_RDY: begin
                    r_vy    <= w_reg_rd;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_status <= w_stat;
                    r_pc     <= w_next;
                    r_cnt    <= '0;
                    if (w_opc == 4'hD && w_n != 4'd0) begin
                        r_state <= S_DRA;
                    end else if (w_opc == 4'hF && w_nn == NN_BCD) begin
                        r_state <= S_BCD;
                    end else if (w_opc == 4'hF && w_nn == NN_STORE) begin
                        r_state <= S_STO;
                    end else if (w_opc == 4'hF && w_nn == NN_LOAD) begin
                        r_state <= S_LDA;
                    end else begin
                        r_state <= S_DONE;
                    end
                    case (w_opc)
                        4'h0: begin
                            if (r_ins == INS_CLS) begin
                                for (int k = 0; k < C_SCREEN_H; k++) begin
                                    r_frame[k] <= '0;
                                end
                            end else if (r_ins == INS_RET && r_sp != '0) begin
                                r_sp <= w_sp_dec;
                            end
                        end
                        4'h2: begin
                            if (w_stat == ST_OK) begin
                                r_sp <= r_sp + 1'b1;
                            end
                        end
                        4'h6, 4'h7, 4'hC: begin
                            r_regs[w_x] <= w_alu_rsp.res;
                        end
                        4'h8: begin
                            case (w_n)
                                4'h0, 4'h1, 4'h2, 4'h3: begin
                                    r_regs[w_x] <= w_alu_rsp.res;
                                end
                                4'h4, 4'h5, 4'h6, 4'h7, 4'hE: begin
                                    // A result aimed at VF replaces the flag.
                                    if (w_x != 4'hF) begin
                                        r_regs[15] <= {7'd0, w_alu_rsp.flag};
                                    end
                                    r_regs[w_x] <= w_alu_rsp.res;
                                end
                                default: r_regs[w_x] <= r_regs[w_x];
                            endcase
                        end
                        4'hA: begin
                            r_i <= {4'd0, w_nnn};
                        end
                        4'hD: begin
                            r_regs[15] <= 8'd0;
                        end
                        4'hF: begin
                            case (w_nn)
                                NN_GETDT: r_regs[w_x] <= r_dt;
                                NN_SETDT: r_dt <= r_vx;
                                NN_SETST: r_st <= r_vx;
                                NN_ADDI: begin
                                    r_i        <= w_i_sum;
                                    r_regs[15] <= {7'd0, (w_i_sum > 16'h0FFF)};
                                end
                                NN_FONT: begin
                                    r_i <= {10'd0, r_vx[3:0], 2'b00} + {12'd0, r_vx[3:0]};
                                end
                                default:  r_dt <= r_dt;
                            endcase
                        end
                        default: ;
                    endcase
                end
                S_DRA: begin
                    r_state <= S_DRB;
                end
                S_DRB: begin
                    r_frame[w_draw_row] <= w_frame_rd ^ w_mask;
                    if ((w_frame_rd & w_mask) != 64'd0) begin
                        r_regs[15] <= 8'd1;
                    end
                    if (r_cnt == 4'(w_n - 4'd1)) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= S_DRA;
                    end
                end
                S_STO: begin
                    if (r_cnt == w_x) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_LDA: begin
                    r_state <= S_LDB;
                end
                S_LDB: begin
                    r_regs[r_cnt] <= w_rdata;
                    if (r_cnt == w_x) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt   <= r_cnt + 4'd1;
                        r_state <= S_LDA;
                    end
                end
                S_BCD: begin
                    if (r_cnt == 4'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Return addresses and the output transaction hold payload only.
    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC && w_opc == 4'h2 && w_stat == ST_OK) begin
            r_stack[r_sp[SI_W-1:0]] <= r_pc + 12'd2;
        end
        if (r_state == S_DONE && (!r_out_valid || !i_out_stall)) begin
            r_out.status      <= r_status;
            r_out.pc_now      <= r_pc;
            r_out.row_bits    <= r_row;
            r_out.sound_level <= r_st;
        end
    end

`ifndef ASSERT_OFF
    a_sp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack level beyond stack depth");

    a_sp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$stable(r_sp)) |->
        (r_sp == $past(r_sp) + 1'b1 || r_sp == $past(r_sp) - 1'b1))
        else $error("stack level moved by more than one");

    a_load_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.op == OP_LOAD) |=> (r_state == S_DONE))
        else $error("load transaction did not go straight to completion");
`endif

endmodule
